FILE: hw/rtl/polar_to_cartesian_unit_defines.svh
// Assertion helpers shared by the RTL
`ifndef POLAR_TO_CARTESIAN_UNIT_DEFINES_SVH
`define POLAR_TO_CARTESIAN_UNIT_DEFINES_SVH

// Same-cycle implication
`define P2C_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define P2C_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/p2c_pkg.sv
package p2c_pkg;

    typedef enum logic [1:0] {
        ACT_PHASE = 2'd0,
        ACT_AMP   = 2'd1,
        ACT_EMIT  = 2'd2
    } action_t;

    // Binary angle: 2^32 per turn
    localparam int ANGLE_W       = 32;
    localparam int PHASE_FRAC    = 16;
    localparam int COEF_W        = 32;
    localparam int COEF_FRAC     = 30;
    localparam int ANGLE_TAB_LEN = 24;

    localparam logic signed [31:0] RAD_TO_TURN_Q16 = 32'sd683565276;
    localparam logic [31:0]        ANGLE_ROUND     = 32'd32768;
    localparam logic [31:0]        HALF_QUADRANT   = 32'h2000_0000;
    localparam logic [31:0]        COEF_ROUND      = 32'h2000_0000;

    // atan(2^-i), 2^32 per turn
    localparam logic signed [ANGLE_W-1:0] ANGLE_TAB [ANGLE_TAB_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Squared CORDIC gain, Q60
    function automatic logic [63:0] p2c_gain_p(input int steps);
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < ANGLE_TAB_LEN; i++)
        begin
            if (i < steps)
            begin
                p = p + (p >> (2 * i));
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] p2c_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        r   = '0;
        b   = 64'd1 << 62;
        rem = v;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/p2c_in_if.sv
interface p2c_in_if #(
    parameter int DATA_WIDTH = 24
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [DATA_WIDTH-1:0] amplitude;
    logic signed [DATA_WIDTH-1:0] phase;

    modport source (output valid, output action, output amplitude, output phase, input ready);
    modport sink   (input valid, input action, input amplitude, input phase, output ready);
endinterface

FILE: hw/rtl/p2c_out_if.sv
interface p2c_out_if #(
    parameter int DATA_WIDTH = 24
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [DATA_WIDTH-1:0] y_value;

    modport source (output valid, output x_value, output y_value, input ready);
    modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

FILE: hw/rtl/polar_to_cartesian_unit.sv
// Pipeline registers in order: input, phase product, quadrant split, CORDIC stages, quadrant fold, result.
// Throughput: one beat per cycle while no back-pressure stalls it; one CORDIC iteration per pipeline stage.
// Each stage holds its beat under back-pressure and refills as soon as its successor moves.
// Reset (rst_n low, asynchronous): pipeline emptied, stored amplitude and phase cleared to 0.
`include "polar_to_cartesian_unit_defines.svh"

module polar_to_cartesian_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int DATA_WIDTH   = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    p2c_in_if.sink      req,
    p2c_out_if.source   rsp
);
    import p2c_pkg::*;

    localparam int STEPS   = (CORDIC_STEPS > ANGLE_TAB_LEN) ? ANGLE_TAB_LEN : CORDIC_STEPS;
    localparam int PROD_W  = DATA_WIDTH + 32;
    localparam int SCALE_W = DATA_WIDTH + COEF_W;
    localparam int SHIFT_W = DATA_WIDTH + 2;

    localparam logic [63:0] GAIN_P   = p2c_gain_p(STEPS);
    localparam logic [63:0] GAIN_Q30 = (64'd1 << 60) / p2c_isqrt(GAIN_P);
    localparam logic signed [COEF_W-1:0] X_INIT = COEF_W'(GAIN_Q30);

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [SHIFT_W-1:0] v);
        logic signed [DATA_WIDTH-1:0] res;
        if (v[SHIFT_W-1:DATA_WIDTH-1] == {3{v[SHIFT_W-1]}})
        begin
            res = v[DATA_WIDTH-1:0];
        end
        else if (v[SHIFT_W-1])
        begin
            res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    logic accept;
    logic emits;

    logic signed [DATA_WIDTH-1:0] held_amp_reg, held_amp_next;
    logic signed [DATA_WIDTH-1:0] held_phase_reg, held_phase_next;

    logic                         in_v_reg;
    logic signed [DATA_WIDTH-1:0] in_amp_reg;
    logic signed [DATA_WIDTH-1:0] in_phase_reg;

    logic                         mul_v_reg;
    logic signed [DATA_WIDTH-1:0] mul_amp_reg;
    logic signed [PROD_W-1:0]     mul_prod_reg, mul_prod_next;

    logic                         ang_v_reg;
    logic signed [DATA_WIDTH-1:0] ang_amp_reg;
    logic [1:0]                   ang_q_reg, ang_q_next;
    logic signed [ANGLE_W-1:0]    ang_z_reg, ang_z_next;
    logic [PROD_W-1:0]            ang_sum;
    logic [ANGLE_W-1:0]           ang_turn;
    logic [ANGLE_W-1:0]           ang_biased;

    logic                         cor_v_reg   [STEPS];
    logic signed [DATA_WIDTH-1:0] cor_amp_reg [STEPS];
    logic [1:0]                   cor_q_reg   [STEPS];
    logic signed [COEF_W-1:0]     cor_x_reg   [STEPS];
    logic signed [COEF_W-1:0]     cor_y_reg   [STEPS];
    logic signed [ANGLE_W-1:0]    cor_z_reg   [STEPS];
    logic                         cor_rdy     [STEPS];

    logic                         rot_v_reg;
    logic signed [SCALE_W-1:0]    rot_px_reg, rot_px_next;
    logic signed [SCALE_W-1:0]    rot_py_reg, rot_py_next;
    logic signed [COEF_W-1:0]     rot_c;
    logic signed [COEF_W-1:0]     rot_s;

    logic                         out_v_reg, out_v_next;
    logic signed [DATA_WIDTH-1:0] out_x_reg, out_x_next;
    logic signed [DATA_WIDTH-1:0] out_y_reg, out_y_next;
    logic [SCALE_W-1:0]           out_x_sum;
    logic [SCALE_W-1:0]           out_y_sum;

    logic in_rdy, mul_rdy, ang_rdy, rot_rdy, out_rdy;

    // Ready ripples back from the result register through every stage
    assign out_rdy   = !out_v_reg || rsp.ready;
    assign rot_rdy   = !rot_v_reg || out_rdy;
    assign ang_rdy   = !ang_v_reg || cor_rdy[0];
    assign mul_rdy   = !mul_v_reg || ang_rdy;
    assign in_rdy    = !in_v_reg || mul_rdy;
    assign req.ready = in_rdy;

    assign accept = req.valid && req.ready;
    assign emits  = (req.action == ACT_AMP) || (req.action == ACT_EMIT);

    // Stored state
    always_comb
    begin
        held_amp_next   = held_amp_reg;
        held_phase_next = held_phase_reg;
        if (accept && (req.action == ACT_AMP))
        begin
            held_amp_next = req.amplitude;
        end
        if (accept && (req.action == ACT_PHASE))
        begin
            held_phase_next = req.phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_amp_reg   <= '0;
            held_phase_reg <= '0;
        end
        else
        begin
            held_amp_reg   <= held_amp_next;
            held_phase_reg <= held_phase_next;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_rdy)
        begin
            in_v_reg <= req.valid && emits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emits)
        begin
            in_amp_reg   <= held_amp_next;
            in_phase_reg <= held_phase_reg;
        end
    end

    // Radians to binary angle
    assign mul_prod_next = in_phase_reg * RAD_TO_TURN_Q16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
        end
        else if (mul_rdy)
        begin
            mul_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_rdy && in_v_reg)
        begin
            mul_amp_reg  <= in_amp_reg;
            mul_prod_reg <= mul_prod_next;
        end
    end

    // Quadrant split
    always_comb
    begin
        ang_sum    = mul_prod_reg + PROD_W'(ANGLE_ROUND);
        ang_turn   = ang_sum[PHASE_FRAC +: ANGLE_W];
        ang_biased = ang_turn + HALF_QUADRANT;
        ang_q_next = ang_biased[ANGLE_W-1 -: 2];
        ang_z_next = ang_turn - {ang_q_next, {(ANGLE_W-2){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_v_reg <= 1'b0;
        end
        else if (ang_rdy)
        begin
            ang_v_reg <= mul_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ang_rdy && mul_v_reg)
        begin
            ang_amp_reg <= mul_amp_reg;
            ang_q_reg   <= ang_q_next;
            ang_z_reg   <= ang_z_next;
        end
    end

    // CORDIC rotation, one iteration per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        logic                         v_in;
        logic signed [DATA_WIDTH-1:0] amp_in;
        logic [1:0]                   q_in;
        logic signed [COEF_W-1:0]     x_in, y_in;
        logic signed [ANGLE_W-1:0]    z_in;
        logic                         rdy_down;
        logic signed [COEF_W-1:0]     cx_next, cy_next;
        logic signed [ANGLE_W-1:0]    cz_next;

        if (i == 0)
        begin : g_first
            assign v_in   = ang_v_reg;
            assign amp_in = ang_amp_reg;
            assign q_in   = ang_q_reg;
            assign x_in   = X_INIT;
            assign y_in   = '0;
            assign z_in   = ang_z_reg;
        end
        else
        begin : g_next
            assign v_in   = cor_v_reg[i-1];
            assign amp_in = cor_amp_reg[i-1];
            assign q_in   = cor_q_reg[i-1];
            assign x_in   = cor_x_reg[i-1];
            assign y_in   = cor_y_reg[i-1];
            assign z_in   = cor_z_reg[i-1];
        end

        if (i == STEPS - 1)
        begin : g_last
            assign rdy_down = rot_rdy;
        end
        else
        begin : g_mid
            assign rdy_down = cor_rdy[i+1];
        end

        assign cor_rdy[i] = !cor_v_reg[i] || rdy_down;

        always_comb
        begin
            if (!z_in[ANGLE_W-1])
            begin
                cx_next = x_in - (y_in >>> i);
                cy_next = y_in + (x_in >>> i);
                cz_next = z_in - ANGLE_TAB[i];
            end
            else
            begin
                cx_next = x_in + (y_in >>> i);
                cy_next = y_in - (x_in >>> i);
                cz_next = z_in + ANGLE_TAB[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cor_v_reg[i] <= 1'b0;
            end
            else if (cor_rdy[i])
            begin
                cor_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (cor_rdy[i] && v_in)
            begin
                cor_amp_reg[i] <= amp_in;
                cor_q_reg[i]   <= q_in;
                cor_x_reg[i]   <= cx_next;
                cor_y_reg[i]   <= cy_next;
                cor_z_reg[i]   <= cz_next;
            end
        end
    end

    // Quadrant fold and amplitude scaling
    always_comb
    begin
        unique case (cor_q_reg[STEPS-1])
            2'd1:
            begin
                rot_c = -cor_y_reg[STEPS-1];
                rot_s = cor_x_reg[STEPS-1];
            end
            2'd2:
            begin
                rot_c = -cor_x_reg[STEPS-1];
                rot_s = -cor_y_reg[STEPS-1];
            end
            2'd3:
            begin
                rot_c = cor_y_reg[STEPS-1];
                rot_s = -cor_x_reg[STEPS-1];
            end
            default:
            begin
                rot_c = cor_x_reg[STEPS-1];
                rot_s = cor_y_reg[STEPS-1];
            end
        endcase
        rot_px_next = cor_amp_reg[STEPS-1] * rot_c;
        rot_py_next = cor_amp_reg[STEPS-1] * rot_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_v_reg <= 1'b0;
        end
        else if (rot_rdy)
        begin
            rot_v_reg <= cor_v_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rot_rdy && cor_v_reg[STEPS-1])
        begin
            rot_px_reg <= rot_px_next;
            rot_py_reg <= rot_py_next;
        end
    end

    // Round, saturate, result register
    always_comb
    begin
        out_x_sum  = rot_px_reg + SCALE_W'(COEF_ROUND);
        out_y_sum  = rot_py_reg + SCALE_W'(COEF_ROUND);
        out_x_next = sat(out_x_sum[SCALE_W-1:COEF_FRAC]);
        out_y_next = sat(out_y_sum[SCALE_W-1:COEF_FRAC]);
        out_v_next = out_rdy ? rot_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && rot_v_reg)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign rsp.valid   = out_v_reg;
    assign rsp.x_value = out_x_reg;
    assign rsp.y_value = out_y_reg;

    `P2C_ASSERT_NEXT(a_phase_only_on_store, clk, rst_n,
        !(accept && (req.action == ACT_PHASE)), $stable(held_phase_reg),
        "stored phase changed without a phase store")
    `P2C_ASSERT_NEXT(a_amp_only_on_store, clk, rst_n,
        !(accept && (req.action == ACT_AMP)), $stable(held_amp_reg),
        "stored amplitude changed without an amplitude store")
    `P2C_ASSERT_NEXT(a_silent_beat_no_entry, clk, rst_n,
        accept && !emits, !in_v_reg,
        "non-emitting beat entered the pipeline")
    `P2C_ASSERT_NEXT(a_no_result_from_bubble, clk, rst_n,
        !rot_v_reg && (!out_v_reg || rsp.ready), !out_v_reg,
        "result appeared without a beat behind it")
    `P2C_ASSERT_NOW(a_ready_when_drained, clk, rst_n,
        !out_v_reg, req.ready,
        "input stalled while the result register is free")

endmodule

FILE: tb/polar_to_cartesian_unit_tb.sv
module polar_to_cartesian_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import p2c_pkg::*;

    localparam int DATA_WIDTH   = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int ROT_STEPS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic signed [DATA_WIDTH-1:0] FIELD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] FIELD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] HALF_PI   = 24'sd102944;
    localparam logic signed [DATA_WIDTH-1:0] ONE_PI    = 24'sd205887;

    // atan(2^-i), 2^32 per turn
    localparam longint ATAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
    } xy_t;

    typedef struct {
        logic [1:0]                   action;
        logic signed [DATA_WIDTH-1:0] amplitude;
        logic signed [DATA_WIDTH-1:0] phase;
        bit                           drain;
    } beat_t;

    logic clk;
    logic rst_n;

    p2c_in_if  #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
    p2c_out_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_if ();

    polar_to_cartesian_unit #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if.sink),
        .rsp  (rsp_if.source)
    );

    beat_t  pending_beats[$];
    xy_t    expected_xy[$];

    logic signed [DATA_WIDTH-1:0] held_amp;
    logic signed [DATA_WIDTH-1:0] held_phase;
    longint unity_gain;

    bit offer_open;
    int beats_in, results_out, mismatches;
    int phase_loads, amp_loads, re_emits, ignored_beats, drains_done;
    int burst_left, gap_left;
    int hold_left, holds_done, stall_mode, stall_tick;

    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--)
        begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic longint inverse_gain();
        longint unsigned p;
        p = 64'd1 << 60;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            p = p + (p >> (2 * i));
        end
        return longint'((64'd1 << 60) / int_sqrt(p));
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] scale_clip(
        logic signed [DATA_WIDTH-1:0] amp, longint coef);
        logic signed [63:0] v;
        v = (longint'(amp) * coef + (64'sd1 <<< 29)) >>> 30;
        if (v > longint'(FIELD_MAX))
        begin
            return FIELD_MAX;
        end
        if (v < longint'(FIELD_MIN))
        begin
            return FIELD_MIN;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic xy_t rotate_vector(logic signed [DATA_WIDTH-1:0] amp,
                                          logic signed [DATA_WIDTH-1:0] ang);
        logic signed [63:0] turns;
        logic [31:0] bam;
        logic [31:0] shifted;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint cx, cy, rz, dx, dy, cc, ss;
        xy_t r;
        turns   = longint'(ang) * 64'sd683565276 + 64'sd32768;
        bam     = turns[47:16];
        shifted = bam + 32'h2000_0000;
        quad    = shifted[31:30];
        resid   = bam - {quad, 30'd0};
        rz      = longint'($signed(resid));
        cx      = unity_gain;
        cy      = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (rz >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                rz = rz - ATAN_TURNS[i];
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                rz = rz + ATAN_TURNS[i];
            end
        end
        case (quad)
            2'd1:
            begin
                cc = -cy;
                ss = cx;
            end
            2'd2:
            begin
                cc = -cx;
                ss = -cy;
            end
            2'd3:
            begin
                cc = cy;
                ss = -cx;
            end
            default:
            begin
                cc = cx;
                ss = cy;
            end
        endcase
        r.x = scale_clip(amp, cc);
        r.y = scale_clip(amp, ss);
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        int sel;
        int turn;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return FIELD_MAX;
            1: return FIELD_MIN;
            2: return DATA_WIDTH'($urandom_range(0, 511)) - 24'sd256;
            3:
            begin
                turn = $urandom_range(0, 80);
                return DATA_WIDTH'((turn - 40) * 102944 + $urandom_range(0, 8) - 4);
            end
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    task automatic queue_beat(logic [1:0] act, logic signed [DATA_WIDTH-1:0] amp,
                              logic signed [DATA_WIDTH-1:0] ang);
        beat_t b;
        b.action    = act;
        b.amplitude = amp;
        b.phase     = ang;
        b.drain     = 1'b0;
        pending_beats.push_back(b);
    endtask

    task automatic queue_drain();
        beat_t b;
        b.action    = ACT_NONE;
        b.amplitude = '0;
        b.phase     = '0;
        b.drain     = 1'b1;
        pending_beats.push_back(b);
    endtask

    // sender: bursts and gaps, inputs change on the falling edge
    always @(negedge clk)
    begin : sender
        beat_t head;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!offer_open)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_if.valid <= 1'b0;
            end
            else if (pending_beats.size() == 0)
            begin
                req_if.valid <= 1'b0;
            end
            else if (pending_beats[0].drain)
            begin
                req_if.valid <= 1'b0;
                if (expected_xy.size() == 0)
                begin
                    head = pending_beats.pop_front();
                    drains_done++;
                end
            end
            else
            begin
                head = pending_beats.pop_front();
                req_if.action    <= head.action;
                req_if.amplitude <= head.amplitude;
                req_if.phase     <= head.phase;
                req_if.valid     <= 1'b1;
                offer_open = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // receiver: long hold-offs at two points, otherwise a changing stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else if ((holds_done == 0 && beats_in >= 300) || (holds_done == 1 && beats_in >= 900))
        begin
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            stall_tick++;
            if (stall_tick % 80 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                2:       rsp_if.ready <= ($urandom_range(0, 9) != 0);
                default: rsp_if.ready <= (stall_tick % 3 != 0);
            endcase
        end
    end

    // input beats update the predictor
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
        begin
            offer_open = 1'b0;
            beats_in++;
            case (req_if.action)
                ACT_PHASE:
                begin
                    held_phase = req_if.phase;
                    phase_loads++;
                end
                ACT_AMP:
                begin
                    held_amp = req_if.amplitude;
                    expected_xy.push_back(rotate_vector(held_amp, held_phase));
                    amp_loads++;
                end
                ACT_EMIT:
                begin
                    expected_xy.push_back(rotate_vector(held_amp, held_phase));
                    re_emits++;
                end
                default: ignored_beats++;
            endcase
        end
    end

    // result beats against the oldest prediction
    always @(posedge clk)
    begin : result_check
        xy_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            results_out++;
            if (expected_xy.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: unexpected result x=%0d y=%0d", $realtime,
                             rsp_if.x_value, rsp_if.y_value);
                end
                mismatches++;
            end
            else
            begin
                want = expected_xy.pop_front();
                if (rsp_if.x_value !== want.x || rsp_if.y_value !== want.y)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: result %0d exp x=%0d y=%0d got x=%0d y=%0d",
                                 $realtime, results_out, want.x, want.y,
                                 rsp_if.x_value, rsp_if.y_value);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("Timeout with %0d results outstanding", expected_xy.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [1:0] act;
        int r;
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.action    = ACT_PHASE;
        req_if.amplitude = '0;
        req_if.phase     = '0;
        rsp_if.ready     = 1'b0;
        held_amp         = '0;
        held_phase       = '0;
        offer_open       = 1'b0;
        burst_left       = 10;
        gap_left         = 0;
        hold_left        = 0;
        holds_done       = 0;
        stall_mode       = 0;
        stall_tick       = 0;
        unity_gain       = inverse_gain();

        // directed: reset state, quadrants, extremes, saturation, ignored action
        queue_beat(ACT_EMIT, '0, '0);
        queue_beat(ACT_AMP, 24'sd65536, '0);
        queue_beat(ACT_PHASE, '0, HALF_PI);
        queue_beat(ACT_EMIT, '0, '0);
        queue_beat(ACT_PHASE, '0, ONE_PI);
        queue_beat(ACT_AMP, FIELD_MAX, '0);
        queue_beat(ACT_AMP, FIELD_MIN, '0);
        queue_beat(ACT_PHASE, '0, -ONE_PI);
        queue_beat(ACT_EMIT, '0, '0);
        queue_beat(ACT_PHASE, '0, FIELD_MAX);
        queue_beat(ACT_EMIT, '0, '0);
        queue_beat(ACT_PHASE, '0, FIELD_MIN);
        queue_beat(ACT_AMP, -24'sd1, '0);
        queue_beat(ACT_AMP, 24'sd1, '0);
        queue_beat(ACT_PHASE, '0, -24'sd1);
        queue_beat(ACT_AMP, FIELD_MAX, '0);
        queue_beat(ACT_NONE, FIELD_MIN, 24'sd1234567);
        queue_beat(ACT_EMIT, '0, '0);
        queue_beat(ACT_PHASE, '0, 24'sd51472);
        queue_beat(ACT_AMP, FIELD_MAX, '0);
        queue_beat(ACT_PHASE, '0, '0);
        queue_beat(ACT_AMP, FIELD_MIN, '0);
        queue_beat(ACT_PHASE, '0, -HALF_PI);
        queue_beat(ACT_AMP, FIELD_MAX, '0);
        queue_drain();

        for (int k = 0; k < 1400; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 34)
            begin
                act = ACT_PHASE;
            end
            else if (r < 74)
            begin
                act = ACT_AMP;
            end
            else if (r < 97)
            begin
                act = ACT_EMIT;
            end
            else
            begin
                act = ACT_NONE;
            end
            queue_beat(act, pick_value(), pick_value());
            if (k == 450 || k == 1100)
            begin
                queue_drain();
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || offer_open || expected_xy.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);

        $display("Covered %0d input beats: %0d phase loads, %0d amplitude loads, %0d re-emits,",
                 beats_in, phase_loads, amp_loads, re_emits);
        $display("%0d ignored actions, %0d results checked, %0d drains, %0d long hold-offs",
                 ignored_beats, results_out, drains_done, holds_done);
        if (mismatches == 0 && expected_xy.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Mismatches: %0d", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: polar_to_cartesian_unit.f
+incdir+hw/rtl
hw/rtl/p2c_pkg.sv
hw/rtl/p2c_in_if.sv
hw/rtl/p2c_out_if.sv
hw/rtl/polar_to_cartesian_unit.sv
tb/polar_to_cartesian_unit_tb.sv
